@@ design/rgbi_sync_capture_packer_assert.svh @@
// assertion macros used by the capture packer core (rscp_core)
// no dependencies; define NO_ASSERTIONS to compile the checks out
`ifndef RGBI_SYNC_CAPTURE_PACKER_ASSERT_SVH
`define RGBI_SYNC_CAPTURE_PACKER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define RSCP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define RSCP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RSCP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define RSCP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ design/rscp_pkg.sv @@
// shared types, register codes and constants of the capture packer
// no dependencies
package rscp_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 512;

  localparam int HS_W   = 10;
  localparam int VS_W   = 10;
  localparam int FSL_W  = 12;
  localparam int FW_W   = 11;
  localparam int FH_W   = 10;
  localparam int COL_W  = 12;
  localparam int LINE_W = 11;
  localparam int RUN_W  = 12;
  localparam int ADDR_W = 18;
  localparam int FRM_W  = 4;
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  localparam logic [HS_W-1:0]  HS_RST  = HS_W'(40);
  localparam logic [VS_W-1:0]  VS_RST  = VS_W'(40);
  localparam logic [FSL_W-1:0] FSL_RST = FSL_W'(250);
  localparam logic [FW_W-1:0]  FW_RST  = FW_W'(640);
  localparam logic [FH_W-1:0]  FH_RST  = FH_W'(288);

  localparam logic [COL_W-1:0]  COL_MAX    = COL_W'(2047);
  localparam logic [COL_W-1:0]  COL_WRAP   = COL_W'(2046);
  localparam logic [LINE_W-1:0] LINE_MAX   = LINE_W'(1023);
  localparam logic [RUN_W-1:0]  RUN_MAX    = RUN_W'(4095);
  localparam logic [RUN_W-1:0]  RUN_LINE   = RUN_W'(5);
  localparam logic [FRM_W-1:0]  FRAMES_MAX = FRM_W'(15);
  localparam logic [FRM_W-1:0]  SWAP_AFTER = FRM_W'(10);

  localparam logic EV_PIXEL = 1'b0;
  localparam logic EV_FRAME = 1'b1;

  typedef enum logic [2:0] {
    REG_HSHIFT  = 3'd0,
    REG_VSHIFT  = 3'd1,
    REG_COMP    = 3'd2,
    REG_FSLEN   = 3'd3,
    REG_FWIDTH  = 3'd4,
    REG_FHEIGHT = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [HS_W-1:0]  horizontal_shift;
    logic [VS_W-1:0]  vertical_shift;
    logic             composite_mode;
    logic [FSL_W-1:0] frame_sync_length;
    logic [FW_W-1:0]  frame_width;
    logic [FH_W-1:0]  frame_height;
  } cfg_t;

  typedef struct packed {
    logic              event_kind;
    logic [ADDR_W-1:0] write_address;
    logic [7:0]        pixel_pair;
    logic              swap_buffer;
  } res_t;

endpackage

@@ design/rscp_regs.sv @@
// apb-style configuration registers of the capture packer
// depends on rscp_pkg
module rscp_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rscp_pkg::PADDR_W-1:0] paddr,
  input  logic [rscp_pkg::PDATA_W-1:0] pwdata,
  output logic [rscp_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  output rscp_pkg::cfg_t               cfg
);
  import rscp_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_HSHIFT:  cfg_nxt.horizontal_shift  = pwdata[HS_W-1:0];
        REG_VSHIFT:  cfg_nxt.vertical_shift    = pwdata[VS_W-1:0];
        REG_COMP:    cfg_nxt.composite_mode    = pwdata[0];
        REG_FSLEN:   cfg_nxt.frame_sync_length = pwdata[FSL_W-1:0];
        REG_FWIDTH:  cfg_nxt.frame_width       = pwdata[FW_W-1:0];
        REG_FHEIGHT: cfg_nxt.frame_height      = pwdata[FH_W-1:0];
        default:     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_HSHIFT:  prdata = PDATA_W'(cfg_r.horizontal_shift);
      REG_VSHIFT:  prdata = PDATA_W'(cfg_r.vertical_shift);
      REG_COMP:    prdata = PDATA_W'(cfg_r.composite_mode);
      REG_FSLEN:   prdata = PDATA_W'(cfg_r.frame_sync_length);
      REG_FWIDTH:  prdata = PDATA_W'(cfg_r.frame_width);
      REG_FHEIGHT: prdata = PDATA_W'(cfg_r.frame_height);
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.horizontal_shift  <= HS_RST;
      cfg_r.vertical_shift    <= VS_RST;
      cfg_r.composite_mode    <= 1'b0;
      cfg_r.frame_sync_length <= FSL_RST;
      cfg_r.frame_width       <= FW_RST;
      cfg_r.frame_height      <= FH_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

@@ design/rscp_core.sv @@
// sync tracking, position counters and pixel pair packing, one sample per fire
// depends on rscp_pkg and rgbi_sync_capture_packer_assert.svh
module rscp_core #(
  parameter int MAX_WIDTH  = rscp_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = rscp_pkg::MAX_HEIGHT_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  rscp_pkg::cfg_t cfg,
  input  logic           fire,
  input  logic [7:0]     sample,
  output logic           res_valid,
  output rscp_pkg::res_t res
);
  import rscp_pkg::*;

`include "rgbi_sync_capture_packer_assert.svh"

  localparam int MW_BITS = $clog2(MAX_WIDTH + 1);
  localparam int MH_BITS = $clog2(MAX_HEIGHT + 1);
  localparam int WCW = (FW_W > MW_BITS) ? FW_W : MW_BITS;
  localparam int HCW = (FH_W > MH_BITS) ? FH_W : MH_BITS;
  localparam logic [WCW-1:0] MAXW_C = WCW'(MAX_WIDTH);
  localparam logic [HCW-1:0] MAXH_C = HCW'(MAX_HEIGHT);

  logic [COL_W-1:0]  col_r, col_nxt, col_inc;
  logic [LINE_W-1:0] line_r, line_nxt, line_adv;
  logic [3:0]        held_r, held_nxt;
  logic [RUN_W-1:0]  run_r, run_nxt, run_inc;
  logic [ADDR_W-1:0] addr_r, addr_nxt, addr_line;
  logic [FRM_W-1:0]  frames_r, frames_nxt;
  logic              attached_r, attached_nxt;

  logic [FW_W-1:0]        width_eff;
  logic [FH_W-1:0]        height_eff;
  logic [FW_W+FH_W-1:0]   line_prod;
  logic                   is_sync;
  logic                   run_hit;
  logic                   frame_end;
  logic                   pix_ok;
  logic                   swap;

  assign width_eff  = (WCW'(cfg.frame_width) < MAXW_C) ? cfg.frame_width : FW_W'(MAX_WIDTH);
  assign height_eff = (HCW'(cfg.frame_height) < MAXH_C) ? cfg.frame_height
                                                          : FH_W'(MAX_HEIGHT);

  assign is_sync  = cfg.composite_mode ? !sample[4] : (sample[5:4] != 2'b11);
  assign col_inc  = (col_r == COL_MAX) ? COL_WRAP : col_r + COL_W'(1);
  assign run_hit  = (run_r == RUN_LINE);
  assign line_adv = (run_hit && line_r != LINE_MAX) ? line_r + LINE_W'(1) : line_r;
  assign run_inc  = (run_r == RUN_MAX) ? run_r : run_r + RUN_W'(1);

  // line start address, half a byte per sample
  assign line_prod = (FW_W+FH_W)'(line_adv[FH_W-1:0]) * (FW_W+FH_W)'(width_eff);
  assign addr_line = line_prod[ADDR_W:1];

  assign frame_end = cfg.composite_mode ? (run_inc >= cfg.frame_sync_length) : !sample[5];
  assign swap      = frames_r > SWAP_AFTER;
  assign pix_ok    = attached_r && !col_inc[COL_W-1] && !line_r[LINE_W-1]
                     && (col_inc[FW_W-1:0] < width_eff)
                     && (line_r[FH_W-1:0] < height_eff);

  always_comb begin
    col_nxt      = col_r;
    line_nxt     = line_r;
    held_nxt     = held_r;
    run_nxt      = run_r;
    addr_nxt     = addr_r;
    frames_nxt   = frames_r;
    attached_nxt = attached_r;
    res_valid    = 1'b0;
    res          = '0;
    if (is_sync) begin
      line_nxt = line_adv;
      run_nxt  = run_inc;
      col_nxt  = ~{2'b00, cfg.horizontal_shift};
      if (run_hit && !line_adv[LINE_W-1] && attached_r) begin
        addr_nxt = addr_line;
      end
      if (frame_end) begin
        line_nxt = ~{1'b0, cfg.vertical_shift};
        if (!line_adv[LINE_W-1]) begin
          res_valid       = 1'b1;
          res.event_kind  = EV_FRAME;
          res.swap_buffer = swap;
          if (swap) begin
            attached_nxt = 1'b1;
          end
          if (frames_r != FRAMES_MAX) begin
            frames_nxt = frames_r + FRM_W'(1);
          end
        end
      end
    end else if (col_inc[0]) begin
      col_nxt = col_inc;
      if (pix_ok) begin
        res_valid         = 1'b1;
        res.event_kind    = EV_PIXEL;
        res.write_address = addr_r;
        res.pixel_pair    = {sample[3:0], held_r};
        addr_nxt          = addr_r + ADDR_W'(1);
      end
    end else begin
      col_nxt  = col_inc;
      run_nxt  = '0;
      held_nxt = sample[3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      line_r     <= '0;
      held_r     <= '0;
      run_r      <= '0;
      addr_r     <= '0;
      frames_r   <= '0;
      attached_r <= 1'b0;
    end else if (fire) begin
      col_r      <= col_nxt;
      line_r     <= line_nxt;
      held_r     <= held_nxt;
      run_r      <= run_nxt;
      addr_r     <= addr_nxt;
      frames_r   <= frames_nxt;
      attached_r <= attached_nxt;
    end
  end

  `RSCP_ASSERT_SAME(a_pixel_needs_buffer, clk, rst_n,
    fire && res_valid && res.event_kind == EV_PIXEL, attached_r,
    "pixel write without an attached buffer")
  `RSCP_ASSERT_NEXT(a_swap_attaches, clk, rst_n,
    fire && res_valid && res.swap_buffer, attached_r,
    "buffer swap did not attach a buffer")
  `RSCP_ASSERT_NEXT(a_frame_rewinds_line, clk, rst_n,
    fire && res_valid && res.event_kind == EV_FRAME, line_r[LINE_W-1],
    "line not rewound after frame end")
  `RSCP_ASSERT_NEXT(a_addr_advances, clk, rst_n,
    fire && res_valid && res.event_kind == EV_PIXEL,
    addr_r == $past(res.write_address) + ADDR_W'(1),
    "write address did not advance after a pixel write")

endmodule

@@ design/rgbi_sync_capture_packer.sv @@
// rgbi capture packer top level: configuration registers, input register, core and result register
// depends on rscp_pkg, rscp_regs and rscp_core
//
// Takes one captured sample byte per cycle and produces at most one result per
// sample: a packed pixel pair with its frame buffer byte address, or a frame
// finished event that may ask for a fresh buffer. A sample is taken into an
// input register, processed by a single pass of logic that updates the sync and
// position state once the output register can take its result, and any result
// lands in an output register that drives the out_ ports. Throughput is one
// sample per cycle; the only stall is a full output register that is not being
// taken. No clearing pass follows reset. The user must write configuration
// registers over the apb-style port only while no sample is in flight; the
// block itself does not enforce it.
module rgbi_sync_capture_packer #(
  parameter int MAX_WIDTH  = rscp_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = rscp_pkg::MAX_HEIGHT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_sample_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_event_kind,
  output logic [rscp_pkg::ADDR_W-1:0]   out_write_address,
  output logic [7:0]                    out_pixel_pair,
  output logic                          out_swap_buffer,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rscp_pkg::PADDR_W-1:0]  paddr,
  input  logic [rscp_pkg::PDATA_W-1:0]  pwdata,
  output logic [rscp_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import rscp_pkg::*;

  cfg_t       cfg;
  res_t       res;
  logic       res_valid;
  logic       in_valid_r, in_valid_nxt;
  logic [7:0] in_sample_r;
  logic       out_valid_r, out_valid_nxt;
  res_t       out_res_r;
  logic       advance;

  rscp_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rscp_core #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .fire      (advance),
    .sample    (in_sample_r),
    .res_valid (res_valid),
    .res       (res)
  );

  // the held sample moves on whenever the result register can take its result
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_valid && in_ready) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = res_valid;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_sample_r <= in_sample_byte;
    end
    if (advance && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_event_kind    = out_res_r.event_kind;
  assign out_write_address = out_res_r.write_address;
  assign out_pixel_pair    = out_res_r.pixel_pair;
  assign out_swap_buffer   = out_res_r.swap_buffer;

endmodule
